>>> rtl/core/trse_pkg.sv
`timescale 1ns / 1ps

package trse_pkg;

    // largest slot count the report layout carries
    localparam int MAX_SLOTS          = 5;
    localparam int DEFAULT_SLOT_COUNT = 5;

    // report framing
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] MULTI_BYTE = 8'hBB;
    localparam logic [7:0] END_BYTE_A = 8'hCC;
    localparam logic [7:0] END_BYTE_B = 8'h00;

    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] STORE_DEPTH = 5'd24;
    localparam logic [COUNT_W-1:0] COUNT_OVER  = 5'd25;

    // fixed byte offsets inside a report
    localparam logic [COUNT_W-1:0] OFF_START = 5'd0;
    localparam logic [COUNT_W-1:0] OFF_MULTI = 5'd6;
    localparam logic [COUNT_W-1:0] OFF_MASK  = 5'd7;

    // event fields
    localparam int VALUE_W = 17;
    localparam logic [VALUE_W-1:0] VALUE_RELEASE = 17'h1FFFF;

    localparam logic KIND_ABS = 1'b0;
    localparam logic KIND_SYN = 1'b1;

    localparam logic [2:0] CODE_SLOT   = 3'd0;
    localparam logic [2:0] CODE_TRACK  = 3'd1;
    localparam logic [2:0] CODE_X      = 3'd2;
    localparam logic [2:0] CODE_Y      = 3'd3;
    localparam logic [2:0] CODE_REPORT = 3'd4;

    // event steps within one slot job
    localparam logic [2:0] STEP_SLOT     = 3'd0;
    localparam logic [2:0] STEP_TRACK    = 3'd1;
    localparam logic [2:0] STEP_X        = 3'd2;
    localparam logic [2:0] STEP_Y        = 3'd3;
    localparam logic [2:0] REL_LAST_STEP = 3'd2;
    localparam logic [2:0] PRS_LAST_STEP = 3'd4;

    // sequencer commands to the datapath
    typedef struct packed {
        logic capture;
        logic finish;
        logic emit;
    } cmd_t;

    // datapath status to the sequencer
    typedef struct packed {
        logic report_ok;
        logic out_free;
        logic last_evt;
    } stat_t;

    // where one report byte lands in the coordinate store
    typedef struct packed {
        logic       is_coord;
        logic [2:0] slot;
        logic [1:0] lane;
    } byte_map_t;

    function automatic byte_map_t map_byte(input logic [COUNT_W-1:0] idx);
        byte_map_t m;
        logic [COUNT_W-1:0] rel;
        m   = '0;
        rel = idx - 5'd8;
        if (idx inside {[5'd2:5'd5]}) begin
            m.is_coord = 1'b1;
            m.slot     = 3'd0;
            m.lane     = 2'(idx - 5'd2);
        end else if (idx inside {[5'd8:5'd23]}) begin
            m.is_coord = 1'b1;
            m.slot     = 3'(rel[3:2]) + 3'd1;
            m.lane     = rel[1:0];
        end
        return m;
    endfunction

endpackage

>>> rtl/core/trse_ctrl.sv
`timescale 1ns / 1ps

module trse_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tlast,
    output logic           s_tready,
    input  trse_pkg::stat_t stat,
    output trse_pkg::cmd_t  cmd
);
    import trse_pkg::*;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   in_accept;

    // bytes are taken only while collecting
    assign s_tready  = (state_reg == ST_COLLECT);
    assign in_accept = s_tvalid && s_tready;

    // commands
    always_comb begin
        cmd         = '0;
        cmd.capture = in_accept && !s_tlast;
        cmd.finish  = in_accept && s_tlast;
        cmd.emit    = (state_reg == ST_EMIT) && stat.out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (cmd.finish && stat.report_ok) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.emit && stat.last_evt) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/trse_datapath.sv
`timescale 1ns / 1ps

module trse_datapath #(
    parameter int SLOT_COUNT = trse_pkg::DEFAULT_SLOT_COUNT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [7:0]                   in_byte,
    input  trse_pkg::cmd_t               cmd,
    output trse_pkg::stat_t              stat,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         out_kind,
    output logic [2:0]                   out_code,
    output logic [trse_pkg::VALUE_W-1:0] out_value,
    output logic                         out_last
);
    import trse_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // report store: framing bytes and per-slot x/y words
    logic [COUNT_W-1:0]    count_reg;
    logic [7:0]            start_reg;
    logic [7:0]            multi_reg;
    logic [SLOT_COUNT-1:0] mask_reg;
    logic [31:0]           coord_reg [SLOT_COUNT];

    logic [SLOT_COUNT-1:0] held_reg;
    logic [SLOT_COUNT-1:0] rel_pend_reg;
    logic [SLOT_COUNT-1:0] prs_pend_reg;
    logic [2:0]            step_reg;

    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [2:0]            out_code_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  out_last_reg;

    byte_map_t             wmap;
    logic [SLOT_COUNT-1:0] nonzero;
    logic                  end_ok;
    logic                  report_ok;
    logic                  out_free;
    logic                  last_evt;

    // status to the sequencer
    assign stat = '{report_ok: report_ok, out_free: out_free, last_evt: last_evt};

    // byte placement
    assign wmap = map_byte(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture && (count_reg < STORE_DEPTH)) begin
            if (count_reg == OFF_START) begin
                start_reg <= in_byte;
            end
            if (count_reg == OFF_MULTI) begin
                multi_reg <= in_byte;
            end
            if (count_reg == OFF_MASK) begin
                mask_reg <= in_byte[SLOT_COUNT-1:0];
            end
            if (wmap.is_coord && (int'(wmap.slot) < SLOT_COUNT)) begin
                case (wmap.lane)
                    2'd0:    coord_reg[wmap.slot[SLOT_W-1:0]][31:24] <= in_byte;
                    2'd1:    coord_reg[wmap.slot[SLOT_W-1:0]][23:16] <= in_byte;
                    2'd2:    coord_reg[wmap.slot[SLOT_W-1:0]][15:8]  <= in_byte;
                    default: coord_reg[wmap.slot[SLOT_W-1:0]][7:0]   <= in_byte;
                endcase
            end
        end
    end

    // report check at the end mark
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            nonzero[i] = |coord_reg[i];
        end
    end

    assign end_ok    = (in_byte == END_BYTE_A) || (in_byte == END_BYTE_B);
    assign report_ok = (count_reg == STORE_DEPTH) && (start_reg == START_BYTE)
                       && (multi_reg == MULTI_BYTE) && end_ok;

    // current slot job: releases first, then presses, lowest slot first
    logic                  rel_any, prs_any;
    logic [SLOT_W-1:0]     rel_idx, prs_idx, job_idx;
    logic [SLOT_COUNT-1:0] rel_rest, prs_rest;
    logic                  job_final;
    logic                  ev_kind;
    logic [2:0]            ev_code;
    logic [VALUE_W-1:0]    ev_value;

    always_comb begin
        rel_idx = '0;
        prs_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (rel_pend_reg[i]) begin
                rel_idx = SLOT_W'(i);
            end
            if (prs_pend_reg[i]) begin
                prs_idx = SLOT_W'(i);
            end
        end
    end

    assign rel_any  = |rel_pend_reg;
    assign prs_any  = |prs_pend_reg;
    assign rel_rest = rel_pend_reg & (rel_pend_reg - 1'b1);
    assign prs_rest = prs_pend_reg & (prs_pend_reg - 1'b1);
    assign job_idx  = rel_any ? rel_idx : prs_idx;

    // event for the current step
    always_comb begin
        ev_kind   = KIND_SYN;
        ev_code   = CODE_REPORT;
        ev_value  = '0;
        job_final = 1'b1;
        last_evt  = 1'b1;
        if (rel_any) begin
            job_final = (step_reg == REL_LAST_STEP);
            last_evt  = job_final && (rel_rest == '0) && !prs_any;
            case (step_reg)
                STEP_SLOT: begin
                    ev_kind  = KIND_ABS;
                    ev_code  = CODE_SLOT;
                    ev_value = VALUE_W'(job_idx);
                end
                STEP_TRACK: begin
                    ev_kind  = KIND_ABS;
                    ev_code  = CODE_TRACK;
                    ev_value = VALUE_RELEASE;
                end
                default: ;
            endcase
        end else if (prs_any) begin
            job_final = (step_reg == PRS_LAST_STEP);
            last_evt  = job_final && (prs_rest == '0);
            case (step_reg)
                STEP_SLOT: begin
                    ev_kind  = KIND_ABS;
                    ev_code  = CODE_SLOT;
                    ev_value = VALUE_W'(job_idx);
                end
                STEP_TRACK: begin
                    ev_kind  = KIND_ABS;
                    ev_code  = CODE_TRACK;
                    ev_value = VALUE_W'(job_idx);
                end
                STEP_X: begin
                    ev_kind  = KIND_ABS;
                    ev_code  = CODE_X;
                    ev_value = VALUE_W'(coord_reg[job_idx][31:16]);
                end
                STEP_Y: begin
                    ev_kind  = KIND_ABS;
                    ev_code  = CODE_Y;
                    ev_value = VALUE_W'(coord_reg[job_idx][15:0]);
                end
                default: ;
            endcase
        end
    end

    // byte count, held marks, job bits and step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            held_reg     <= '0;
            rel_pend_reg <= '0;
            prs_pend_reg <= '0;
            step_reg     <= '0;
        end else begin
            if (cmd.capture && (count_reg < COUNT_OVER)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.finish) begin
                count_reg <= '0;
                if (report_ok) begin
                    rel_pend_reg <= held_reg & ~mask_reg;
                    prs_pend_reg <= mask_reg & nonzero;
                    held_reg     <= mask_reg & (nonzero | held_reg);
                    step_reg     <= '0;
                end
            end
            if (cmd.emit) begin
                if (job_final) begin
                    step_reg <= '0;
                    if (rel_any) begin
                        rel_pend_reg <= rel_rest;
                    end else begin
                        prs_pend_reg <= prs_rest;
                    end
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg  <= ev_kind;
            out_code_reg  <= ev_code;
            out_value_reg <= ev_value;
            out_last_reg  <= last_evt;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_code  = out_code_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

>>> rtl/core/touch_report_to_slot_events_unit.sv
`timescale 1ns / 1ps

// Touch report to multitouch slot events.
// Input stream: one report byte per item on s_tdata, s_tlast on the final
// byte of a report. Only a 25-byte report with the right start, multi-start
// and end bytes produces output; any other report is dropped silently.
// Output stream: one event per item. m_tuser is the kind (0 axis, 1 sync),
// m_tlast marks the final event of a report.
// Timing: bytes are taken one per cycle while the block collects. After the
// end byte of a valid report the sequencer enters its emit state and loads
// the first event into the output register, then one event per cycle while
// m_tready is high, 1 to 25 events per report. The event sequencer walks
// release jobs (3 events) then press jobs (5 events), one event a cycle; s_tready
// is low from the end byte until the final event has been loaded into the output register.
// A stall on m_tready holds the output register and the sequencer; the next
// report's bytes are taken as soon as the final event has been loaded.
// Reset: byte count and held slot marks clear, output empty; the report
// store holds nothing defined until bytes arrive.
module touch_report_to_slot_events_unit #(
    parameter int SLOT_COUNT = trse_pkg::DEFAULT_SLOT_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_report
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] event_code, [19:3] event_value, [23:20] zero
    output logic [0:0]  m_tuser,   // [0] event_kind
    output logic        m_tlast    // last_event
);
    import trse_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic               ev_kind;
    logic [2:0]         ev_code;
    logic [VALUE_W-1:0] ev_value;

    // sequencer
    trse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, held marks and event build
    trse_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (ev_kind),
        .out_code  (ev_code),
        .out_value (ev_value),
        .out_last  (m_tlast)
    );

    // pack the event
    assign m_tdata = {4'd0, ev_value, ev_code};
    assign m_tuser = ev_kind;

endmodule
